/* sv/sdsc_pkg.sv */
// shared types, codes and helper functions of the sd spi command engine
`timescale 1ns / 1ps

package sdsc_pkg;

  // item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_RX    = 1'b1;

  // response kinds
  localparam logic [2:0] KIND_R1      = 3'd0;
  localparam logic [2:0] KIND_R1B     = 3'd1;
  localparam logic [2:0] KIND_R2      = 3'd2;
  localparam logic [2:0] KIND_R3      = 3'd3;
  localparam logic [2:0] KIND_R7      = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  // completion status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  // configuration register indexes
  localparam logic REG_RESP_WAIT = 1'b0;
  localparam logic REG_BUSY_WAIT = 1'b1;

  // register reset values
  localparam logic [15:0] RESP_WAIT_RESET = 16'hffff;
  localparam logic [23:0] BUSY_WAIT_RESET = 24'hffffff;

  // frame constants
  localparam logic [7:0] DUMMY_BYTE    = 8'hff;
  localparam logic [1:0] CMD_START_BITS = 2'b01;
  localparam logic [6:0] CRC7_POLY     = 7'h09;
  localparam logic [2:0] FRAME_TAIL    = 3'd6;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_WAIT    = 4'b0010,
    PH_COLLECT = 4'b0100,
    PH_BUSY    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [5:0]  cmd_index;
    logic        is_app;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_frame;
    logic [7:0]  tx_byte;
    logic        status;
    logic [14:0] error_bits;
    logic [31:0] reg_word;
    logic [2:0]  response_kind;
    logic        last;
  } out_item_t;

  // request from the engine to the emitter
  typedef struct packed {
    logic        load;
    logic        is_frame;
    logic [39:0] frame_bytes;
    out_item_t   report;
  } emit_req_t;

  // one byte of crc7, msb first
  function automatic logic [6:0] crc7_update(input logic [6:0] crc_in, input logic [7:0] data);
    logic [6:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[6] ^ data[i];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

  // a frame transfer
  function automatic out_item_t frame_item(input logic [7:0] tx, input logic is_last);
    out_item_t o;
    o               = '0;
    o.is_frame      = 1'b1;
    o.tx_byte       = tx;
    o.last          = is_last;
    return o;
  endfunction

  // standard command response kinds
  function automatic logic [2:0] cmd_kind(input logic [5:0] c);
    logic [2:0] k;
    case (c) inside
      6'd0, 6'd1, 6'd6, 6'd9, 6'd10, 6'd16, 6'd17, 6'd18, 6'd24, 6'd25, 6'd27,
      6'd30, 6'd32, 6'd33, 6'd42, 6'd55, 6'd56, 6'd59: k = KIND_R1;
      6'd12, 6'd28, 6'd29, 6'd38:                      k = KIND_R1B;
      6'd13:                                           k = KIND_R2;
      6'd58:                                           k = KIND_R3;
      6'd8:                                            k = KIND_R7;
      default:                                         k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // application command response kinds
  function automatic logic [2:0] acmd_kind(input logic [5:0] c);
    logic [2:0] k;
    case (c) inside
      6'd22, 6'd23, 6'd41, 6'd42, 6'd51: k = KIND_R1;
      6'd13:                             k = KIND_R2;
      default:                           k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // response bytes collected for each kind
  function automatic logic [2:0] kind_length(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      KIND_R1, KIND_R1B: n = 3'd1;
      KIND_R2:           n = 3'd2;
      KIND_R3, KIND_R7:  n = 3'd5;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

/* sv/sdsc_cfg.sv */
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module sdsc_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [15:0] resp_limit,
  output logic [23:0] busy_limit
);

  logic [15:0] resp_limit_r;
  logic [23:0] busy_limit_r;
  logic        wr_en;
  logic        reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_limit_r <= sdsc_pkg::RESP_WAIT_RESET;
      busy_limit_r <= sdsc_pkg::BUSY_WAIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        sdsc_pkg::REG_RESP_WAIT: resp_limit_r <= cfg_pwdata[15:0];
        sdsc_pkg::REG_BUSY_WAIT: busy_limit_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      sdsc_pkg::REG_RESP_WAIT: cfg_prdata = {16'd0, resp_limit_r};
      sdsc_pkg::REG_BUSY_WAIT: cfg_prdata = {8'd0, busy_limit_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign resp_limit = resp_limit_r;
  assign busy_limit = busy_limit_r;

endmodule

/* sv/sdsc_engine.sv */
// command phase logic: framing requests, response wait, collect and busy wait
`timescale 1ns / 1ps

module sdsc_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  sdsc_pkg::in_item_t item,
  input  logic [15:0]        resp_limit,
  input  logic [23:0]        busy_limit,
  output sdsc_pkg::emit_req_t req
);

  sdsc_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [23:0] wait_count_r, wait_count_nxt;
  logic [2:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  store_r [5];

  logic        st_we;
  logic [24:0] wait_inc;
  logic [23:0] busy_base;
  logic [24:0] busy_inc;
  logic        produce;
  logic        is_frame;
  logic        do_finish;
  logic        do_timeout;
  logic        busy_path;
  logic [7:0]  r1;
  logic [7:0]  r2;
  logic [31:0] rw;
  sdsc_pkg::out_item_t report;

  assign wait_inc  = {1'b0, wait_count_r} + 25'd1;
  assign busy_base = (phase_r == sdsc_pkg::PH_COLLECT) ? 24'd0 : wait_count_r;
  assign busy_inc  = {1'b0, busy_base} + 25'd1;

  // next state and result selection
  always_comb begin
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    wait_count_nxt = wait_count_r;
    byte_index_nxt = byte_index_r;
    st_we          = 1'b0;
    is_frame       = 1'b0;
    do_finish      = 1'b0;
    do_timeout     = 1'b0;
    busy_path      = 1'b0;
    if (item.mode == sdsc_pkg::MODE_START) begin
      is_frame       = 1'b1;
      kind_nxt       = item.is_app ? sdsc_pkg::acmd_kind(item.cmd_index)
                                   : sdsc_pkg::cmd_kind(item.cmd_index);
      phase_nxt      = sdsc_pkg::PH_WAIT;
      wait_count_nxt = '0;
      byte_index_nxt = '0;
    end else begin
      case (phase_r)
        sdsc_pkg::PH_WAIT: begin
          if (item.rx_byte[7]) begin
            if (wait_inc >= {9'd0, resp_limit}) begin
              do_timeout = 1'b1;
            end else begin
              wait_count_nxt = wait_inc[23:0];
            end
          end else if (kind_r == sdsc_pkg::KIND_UNKNOWN) begin
            do_finish = 1'b1;
          end else begin
            st_we          = 1'b1;
            byte_index_nxt = 3'd1;
            phase_nxt      = sdsc_pkg::PH_COLLECT;
          end
        end
        sdsc_pkg::PH_COLLECT: begin
          if (byte_index_r < sdsc_pkg::kind_length(kind_r)) begin
            st_we          = 1'b1;
            byte_index_nxt = byte_index_r + 3'd1;
          end else if (kind_r == sdsc_pkg::KIND_R1B) begin
            busy_path = 1'b1;
          end else begin
            do_finish = 1'b1;
          end
        end
        sdsc_pkg::PH_BUSY: busy_path = 1'b1;
        default: ;
      endcase
      // card busy while it returns zero bytes
      if (busy_path) begin
        if (item.rx_byte != 8'd0) begin
          do_finish = 1'b1;
        end else if (busy_inc >= {1'b0, busy_limit}) begin
          do_timeout = 1'b1;
        end else begin
          wait_count_nxt = busy_inc[23:0];
          phase_nxt      = sdsc_pkg::PH_BUSY;
        end
      end
      if (do_finish || do_timeout) begin
        phase_nxt = sdsc_pkg::PH_IDLE;
      end
    end
  end

  // completion report from the collected bytes
  always_comb begin
    r1 = (kind_r <= sdsc_pkg::KIND_R7) ? store_r[0] : 8'd0;
    r2 = (kind_r == sdsc_pkg::KIND_R2) ? store_r[1] : 8'd0;
    rw = (kind_r == sdsc_pkg::KIND_R3 || kind_r == sdsc_pkg::KIND_R7)
         ? {store_r[1], store_r[2], store_r[3], store_r[4]} : 32'd0;
    report               = '0;
    report.is_frame      = 1'b0;
    report.response_kind = kind_r;
    if (do_timeout) begin
      report.status = sdsc_pkg::STATUS_TIMEOUT;
    end else begin
      report.status     = sdsc_pkg::STATUS_DONE;
      report.error_bits = {r1[6:0], r2};
      report.reg_word   = rw;
    end
  end

  assign produce         = is_frame | do_finish | do_timeout;
  assign req.load        = fire & produce;
  assign req.is_frame    = is_frame;
  assign req.frame_bytes = {sdsc_pkg::CMD_START_BITS, item.cmd_index, item.argument};
  assign req.report      = report;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdsc_pkg::PH_IDLE;
      kind_r       <= sdsc_pkg::KIND_R1;
      wait_count_r <= '0;
      byte_index_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      wait_count_r <= wait_count_nxt;
      byte_index_r <= byte_index_nxt;
    end
  end

  // response byte store
  always_ff @(posedge clk) begin
    if (fire && st_we) begin
      store_r[byte_index_r] <= item.rx_byte;
    end
  end

endmodule

/* sv/sdsc_emit.sv */
// result register: one completion report or a seven-byte frame run with crc7
`timescale 1ns / 1ps

module sdsc_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdsc_pkg::emit_req_t  req,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sdsc_pkg::out_item_t  out_data
);

  logic                vld_r, vld_nxt;
  sdsc_pkg::out_item_t res_r, res_nxt;
  logic [39:0]         shift_r, shift_nxt;
  logic [2:0]          rem_r, rem_nxt;
  logic [6:0]          crc_r, crc_nxt;
  logic                out_acc;

  assign out_acc = vld_r & ~out_stall;
  assign ready   = ~vld_r | (out_acc & (rem_r == 3'd0));

  // next transfer
  always_comb begin
    vld_nxt   = vld_r;
    res_nxt   = res_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    crc_nxt   = crc_r;
    if (req.load) begin
      vld_nxt = 1'b1;
      if (req.is_frame) begin
        res_nxt   = sdsc_pkg::frame_item(sdsc_pkg::DUMMY_BYTE, 1'b0);
        shift_nxt = req.frame_bytes;
        rem_nxt   = sdsc_pkg::FRAME_TAIL;
        crc_nxt   = '0;
      end else begin
        res_nxt = req.report;
        rem_nxt = 3'd0;
      end
    end else if (out_acc) begin
      if (rem_r == 3'd0) begin
        vld_nxt = 1'b0;
      end else if (rem_r == 3'd1) begin
        res_nxt = sdsc_pkg::frame_item({crc_r, 1'b1}, 1'b1);
        rem_nxt = 3'd0;
      end else begin
        // one command byte out, one byte into the crc
        res_nxt   = sdsc_pkg::frame_item(shift_r[39:32], 1'b0);
        crc_nxt   = sdsc_pkg::crc7_update(crc_r, shift_r[39:32]);
        shift_nxt = {shift_r[31:0], 8'd0};
        rem_nxt   = rem_r - 3'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    shift_r <= shift_nxt;
    crc_r   <= crc_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = res_r;

endmodule

/* sv/sd_spi_command_transaction_top.sv */
// top level of the sd spi mode command engine
//
//   port group  direction  handshake           payload
//   in_         input      in_valid/in_stall    sdsc_pkg::in_item_t
//   out_        output     out_valid/out_stall  sdsc_pkg::out_item_t
//   cfg_        input      apb psel/penable     two limit registers, 32-bit data
//
// an item is registered on transfer and handled by the phase logic; a receive
// item gives at most one report, so receive items flow one per cycle. a start
// item gives a seven-byte frame from the result register, one byte per cycle,
// and the input holds off until its last byte is taken, with the crc7 built one
// byte per cycle. rst_n is synchronous; after reset the engine is idle. out_stall
// holds the result register, pausing both flows, and backs up to in_stall.
`timescale 1ns / 1ps

module sd_spi_command_transaction_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sdsc_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  sdsc_pkg::in_item_t  item_r;
  logic                item_vld_r, item_vld_nxt;
  logic                emit_ready;
  logic                fire;
  logic                in_acc;
  logic [15:0]         resp_limit;
  logic [23:0]         busy_limit;
  sdsc_pkg::emit_req_t req;

  assign fire     = item_vld_r & emit_ready;
  assign in_stall = item_vld_r & ~emit_ready;
  assign in_acc   = in_valid & ~in_stall;

  assign item_vld_nxt = in_acc | (item_vld_r & ~fire);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  sdsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .resp_limit  (resp_limit),
    .busy_limit  (busy_limit)
  );

  sdsc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item_r),
    .resp_limit (resp_limit),
    .busy_limit (busy_limit),
    .req        (req)
  );

  sdsc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* bench/sd_spi_command_transaction_checker.sv */
// checker for the sd spi command engine: tracks the engine state and compares every result
`timescale 1ns / 1ps

module sd_spi_command_transaction_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sdsc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sdsc_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output int                  errors,
  output int                  results_due,
  output int                  frames_seen,
  output int                  reports_seen,
  output int                  timeouts_seen
);
  import sdsc_pkg::*;

  // results still owed by the engine, oldest first
  out_item_t   due_results [$];

  // tracked engine state and limits
  phase_t      cmd_phase;
  logic [2:0]  held_kind;
  logic [23:0] wait_cnt;
  logic [2:0]  rx_idx;
  logic [7:0]  resp_bytes [5];
  logic [15:0] resp_limit;
  logic [23:0] busy_limit;

  initial begin
    errors        = 0;
    results_due   = 0;
    frames_seen   = 0;
    reports_seen  = 0;
    timeouts_seen = 0;
  end

  // crc7 over one byte, msb first
  function automatic logic [6:0] crc7_next(input logic [6:0] crc, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'd0);
    end
    return c;
  endfunction

  // response kind from the standard or application table
  function automatic logic [2:0] kind_of(input logic [5:0] c, input logic app);
    logic [2:0] k;
    if (app) begin
      case (c)
        6'd22, 6'd23, 6'd41, 6'd42, 6'd51: k = KIND_R1;
        6'd13:                             k = KIND_R2;
        default:                           k = KIND_UNKNOWN;
      endcase
    end else begin
      case (c)
        6'd0, 6'd1, 6'd6, 6'd9, 6'd10, 6'd16, 6'd17, 6'd18, 6'd24, 6'd25,
        6'd27, 6'd30, 6'd32, 6'd33, 6'd42, 6'd55, 6'd56, 6'd59: k = KIND_R1;
        6'd12, 6'd28, 6'd29, 6'd38:                           k = KIND_R1B;
        6'd13:                                                k = KIND_R2;
        6'd58:                                                k = KIND_R3;
        6'd8:                                                 k = KIND_R7;
        default:                                              k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

  // response bytes gathered before the trailing byte
  function automatic logic [2:0] resp_len(input logic [2:0] k);
    case (k)
      KIND_R1, KIND_R1B: return 3'd1;
      KIND_R2:           return 3'd2;
      KIND_R3, KIND_R7:  return 3'd5;
      default:           return 3'd0;
    endcase
  endfunction

  // completion report, either with the gathered response or as a timeout
  task automatic close_cmd(input logic timed_out);
    out_item_t  r;
    logic [7:0] first;
    logic [7:0] second;
    r      = '0;
    first  = '0;
    second = '0;
    r.response_kind = held_kind;
    if (timed_out) begin
      r.status = STATUS_TIMEOUT;
    end else begin
      r.status = STATUS_DONE;
      if (held_kind <= KIND_R7) first = resp_bytes[0];
      if (held_kind == KIND_R2) second = resp_bytes[1];
      r.error_bits = {first[6:0], second};
      if (held_kind == KIND_R3 || held_kind == KIND_R7) begin
        r.reg_word = {resp_bytes[1], resp_bytes[2], resp_bytes[3], resp_bytes[4]};
      end
    end
    due_results.push_back(r);
    cmd_phase = PH_IDLE;
  endtask

  // one byte of the r1b busy wait
  task automatic busy_step(input logic [7:0] b);
    if (b != 8'h00) begin
      close_cmd(1'b0);
    end else if ({1'b0, wait_cnt} + 25'd1 >= {1'b0, busy_limit}) begin
      close_cmd(1'b1);
    end else begin
      wait_cnt  = wait_cnt + 24'd1;
      cmd_phase = PH_BUSY;
    end
  endtask

  // advance the tracked engine by one accepted item
  task automatic advance_engine(input in_item_t it);
    out_item_t  f;
    logic [7:0] frame [6];
    logic [6:0] crc;
    if (it.mode == MODE_START) begin
      frame[0] = DUMMY_BYTE;
      frame[1] = {CMD_START_BITS, it.cmd_index};
      frame[2] = it.argument[31:24];
      frame[3] = it.argument[23:16];
      frame[4] = it.argument[15:8];
      frame[5] = it.argument[7:0];
      crc = '0;
      for (int i = 0; i < 6; i++) begin
        if (i > 0) crc = crc7_next(crc, frame[i]);
        f          = '0;
        f.is_frame = 1'b1;
        f.tx_byte  = frame[i];
        due_results.push_back(f);
      end
      f          = '0;
      f.is_frame = 1'b1;
      f.tx_byte  = {crc, 1'b1};
      f.last     = 1'b1;
      due_results.push_back(f);
      held_kind = kind_of(it.cmd_index, it.is_app);
      cmd_phase = PH_WAIT;
      wait_cnt  = '0;
      rx_idx    = '0;
    end else begin
      case (cmd_phase)
        PH_WAIT: begin
          if (it.rx_byte[7]) begin
            if ({1'b0, wait_cnt} + 25'd1 >= {9'd0, resp_limit}) close_cmd(1'b1);
            else wait_cnt = wait_cnt + 24'd1;
          end else if (held_kind == KIND_UNKNOWN) begin
            close_cmd(1'b0);
          end else begin
            resp_bytes[0] = it.rx_byte;
            rx_idx        = 3'd1;
            cmd_phase     = PH_COLLECT;
          end
        end
        PH_COLLECT: begin
          if (rx_idx < resp_len(held_kind) && rx_idx < 3'd5) begin
            resp_bytes[rx_idx] = it.rx_byte;
            rx_idx = rx_idx + 3'd1;
          end else if (held_kind == KIND_R1B) begin
            wait_cnt = '0;
            busy_step(it.rx_byte);
          end else begin
            close_cmd(1'b0);
          end
        end
        PH_BUSY: busy_step(it.rx_byte);
        default: ;
      endcase
    end
  endtask

  // watch config writes, result transfers and input transfers
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      due_results.delete();
      cmd_phase  = PH_IDLE;
      held_kind  = '0;
      wait_cnt   = '0;
      rx_idx     = '0;
      resp_limit = RESP_WAIT_RESET;
      busy_limit = BUSY_WAIT_RESET;
      for (int i = 0; i < 5; i++) resp_bytes[i] = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == {REG_RESP_WAIT, 2'b00}) resp_limit = cfg_pwdata[15:0];
        else if (cfg_paddr == {REG_BUSY_WAIT, 2'b00}) busy_limit = cfg_pwdata[23:0];
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (due_results.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result transfer with nothing due: frame=%0b tx=%02h st=%0b",
                     $realtime, got.is_frame, got.tx_byte, got.status);
          end
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got.is_frame !== want.is_frame || got.tx_byte !== want.tx_byte ||
              got.status !== want.status || got.error_bits !== want.error_bits ||
              got.reg_word !== want.reg_word ||
              got.response_kind !== want.response_kind || got.last !== want.last) begin
            if (errors < 10) begin
              $display("%0t: mismatch exp frame=%0b tx=%02h st=%0b err=%04h reg=%08h kind=%0d last=%0b",
                       $realtime, want.is_frame, want.tx_byte, want.status, want.error_bits,
                       want.reg_word, want.response_kind, want.last);
              $display("             got frame=%0b tx=%02h st=%0b err=%04h reg=%08h kind=%0d last=%0b",
                       got.is_frame, got.tx_byte, got.status, got.error_bits,
                       got.reg_word, got.response_kind, got.last);
            end
            errors++;
          end
        end
        if (got.is_frame && got.last) frames_seen++;
        if (!got.is_frame) reports_seen++;
        if (!got.is_frame && got.status == STATUS_TIMEOUT) timeouts_seen++;
      end
      if (in_valid && !in_stall) advance_engine(in_data);
    end
    results_due = due_results.size();
  end

endmodule

/* bench/tb.sv */
// testbench top: drives commands and card bytes into the sd spi command engine
`timescale 1ns / 1ps

module tb;
  import sdsc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int ITEM_TARGET   = 220;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  in_item_t    in_data     = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors;
  int results_due;
  int frames_seen;
  int reports_seen;
  int timeouts_seen;

  int          cycle_cnt     = 0;
  int          items_sent    = 0;
  int          settings_used = 0;
  int          burst_left    = 0;
  bit          steady        = 1'b0;
  bit          hold_start    = 1'b0;
  int unsigned resp_lim_now  = 65535;
  int unsigned busy_lim_now  = 16777215;

  // commands grouped by the response they draw
  logic [5:0] std_r1 [18] = '{6'd0, 6'd1, 6'd6, 6'd9, 6'd10, 6'd16, 6'd17, 6'd18, 6'd24,
                              6'd25, 6'd27, 6'd30, 6'd32, 6'd33, 6'd42, 6'd55, 6'd56, 6'd59};
  logic [5:0] std_r1b [4] = '{6'd12, 6'd28, 6'd29, 6'd38};
  logic [5:0] app_r1 [5]  = '{6'd22, 6'd23, 6'd41, 6'd42, 6'd51};

  always #HALF_PERIOD clk = ~clk;

  sd_spi_command_transaction_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sd_spi_command_transaction_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .errors        (errors),
    .results_due   (results_due),
    .frames_seen   (frames_seen),
    .reports_seen  (reports_seen),
    .timeouts_seen (timeouts_seen)
  );

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results due", cycle_cnt, results_due);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern, rate changes between random-length segments; long hold-off on request
  initial begin : stall_gen
    int unsigned stall_pct;
    int unsigned seg_left;
    int unsigned hold_left;
    stall_pct = 0;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // apb write: setup then access, then back to idle
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] resp_lim, input logic [31:0] busy_lim);
    cfg_write(REG_RESP_WAIT, resp_lim);
    cfg_write(REG_BUSY_WAIT, busy_lim);
    resp_lim_now = resp_lim;
    busy_lim_now = busy_lim;
    settings_used++;
  endtask

  // offer one item in bursts with random gaps, wait for its transfer
  task automatic push_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_start(input logic [5:0] cmd, input logic app, input logic [31:0] arg);
    in_item_t it;
    it.mode      = MODE_START;
    it.cmd_index = cmd;
    it.is_app    = app;
    it.argument  = arg;
    it.rx_byte   = 8'($urandom);
    push_item(it);
    items_sent++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    in_item_t it;
    it.mode      = MODE_RX;
    it.cmd_index = 6'($urandom);
    it.is_app    = 1'($urandom);
    it.argument  = $urandom;
    it.rx_byte   = b;
    push_item(it);
    items_sent++;
  endtask

  // stop offering and wait until every due result has come out
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one command with a plausible card reply, sometimes cut short or corrupted
  task automatic random_command();
    logic [5:0]  cmd;
    logic        app;
    logic [2:0]  k;
    logic [31:0] arg;
    logic [7:0]  reply [$];
    int          sel;
    int          n_wait;
    int          n_data;
    int          n_zero;
    int          keep;
    sel = $urandom_range(0, 99);
    app = 1'b0;
    if (sel < 35) begin
      k   = KIND_R1;
      app = 1'($urandom);
      cmd = app ? app_r1[$urandom_range(0, 4)] : std_r1[$urandom_range(0, 17)];
    end else if (sel < 55) begin
      k   = KIND_R1B;
      cmd = std_r1b[$urandom_range(0, 3)];
    end else if (sel < 65) begin
      k   = KIND_R2;
      cmd = 6'd13;
      app = 1'($urandom);
    end else if (sel < 75) begin
      k   = KIND_R3;
      cmd = 6'd58;
    end else if (sel < 85) begin
      k   = KIND_R7;
      cmd = 6'd8;
    end else begin
      k   = KIND_UNKNOWN;
      cmd = 6'($urandom);
      app = 1'($urandom);
    end
    case ($urandom_range(0, 7))
      0:       arg = 32'h0000_0000;
      1:       arg = 32'hffff_ffff;
      default: arg = $urandom;
    endcase

    // bytes with bit 7 set before the response
    if (resp_lim_now <= 8) n_wait = $urandom_range(0, resp_lim_now + 1);
    else if ($urandom_range(0, 9) == 0) n_wait = $urandom_range(4, 12);
    else n_wait = $urandom_range(0, 3);
    repeat (n_wait) reply.push_back({1'b1, 7'($urandom)});
    reply.push_back({1'b0, 7'($urandom)});
    n_data = (k == KIND_R2) ? 1 : (k == KIND_R3 || k == KIND_R7) ? 4 :
             (k == KIND_UNKNOWN) ? 2 : 0;
    repeat (n_data) reply.push_back(8'($urandom));

    // busy zeros for r1b, then a trailing byte
    if (k == KIND_R1B && $urandom_range(0, 3) != 0) begin
      n_zero = (busy_lim_now <= 8) ? $urandom_range(1, busy_lim_now + 1) : $urandom_range(1, 5);
      repeat (n_zero) reply.push_back(8'h00);
    end
    if (k == KIND_R1B) reply.push_back(8'($urandom_range(1, 255)));
    else reply.push_back(8'($urandom));

    keep = reply.size();
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(0, reply.size());
    if ($urandom_range(0, 9) == 0) reply[$urandom_range(0, reply.size() - 1)] = 8'($urandom);
    send_start(cmd, app, arg);
    for (int i = 0; i < keep; i++) send_rx(reply[i]);
    if ($urandom_range(0, 14) == 0) send_rx(8'($urandom));
  endtask

  initial begin : stimulus
    int phase_no;
    int n_cmds;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray byte while idle, each response shape, unknown command, restart
    send_rx(8'hff);
    send_start(6'd0, 1'b0, 32'h0000_0000);
    send_rx(8'hff);
    send_rx(8'h01);
    send_rx(8'hff);
    send_start(6'd63, 1'b1, 32'hffff_ffff);
    send_rx(8'h80);
    send_rx(8'h7f);
    send_start(6'd8, 1'b0, 32'h0000_01aa);
    send_rx(8'h01);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(8'h01);
    send_rx(8'haa);
    send_rx(8'hff);
    send_start(6'd13, 1'b1, 32'h5555_aaaa);
    send_rx(8'h00);
    send_rx(8'hff);
    send_rx(8'h00);
    send_start(6'd12, 1'b0, 32'h0000_0000);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(8'h5a);
    // start while a command is still waiting for its response
    send_start(6'd58, 1'b0, 32'h8000_0001);
    send_rx(8'h80);
    send_start(6'd17, 1'b0, 32'h1234_5678);
    send_rx(8'h7f);
    send_rx(8'h80);
    drain();

    // random commands under a series of limit settings
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase_no)
        0: set_limits(32'h0000_ffff, 32'h00ff_ffff);
        1: set_limits(32'd1, 32'd1);
        2: set_limits(32'd0, 32'd0);
        3: set_limits(32'd3, 32'd4);
        default: begin
          if ($urandom_range(0, 3) == 0)
            set_limits($urandom_range(9, 65535), $urandom_range(9, 16777215));
          else
            set_limits($urandom_range(1, 8), $urandom_range(1, 8));
        end
      endcase
      steady = (phase_no == 0) || ($urandom_range(0, 3) == 0);
      // long receiver hold-off while commands keep arriving back to back
      if (phase_no == 0) hold_start = 1'b1;
      n_cmds = $urandom_range(4, 9);
      repeat (n_cmds) random_command();
      steady = 1'b0;
      drain();
      phase_no++;
    end

    $display("sent %0d items: %0d command frames, %0d completion reports, %0d timeouts",
             items_sent, frames_seen, reports_seen, timeouts_seen);
    $display("limit settings used: %0d, from zero and one up to full scale", settings_used);
    if (errors == 0 && results_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sdsc_pkg.sv
sv/sdsc_cfg.sv
sv/sdsc_engine.sv
sv/sdsc_emit.sv
sv/sd_spi_command_transaction_top.sv
bench/sd_spi_command_transaction_checker.sv
bench/tb.sv
